### src/kedl_pkg.sv
// ----------------------------------------------------------------------------
// kedl_pkg: shared types and constants for the knife-edge diffraction block
// Fixed-point constants, pipeline record and small helpers.
// ----------------------------------------------------------------------------
package kedl_pkg;

  localparam int unsigned VFrac    = 16;
  localparam int unsigned OutFrac  = 8;
  localparam int unsigned LogFrac  = 28;
  localparam int unsigned VW       = 24;
  localparam int unsigned OW       = 16;

  localparam logic [26:0] DbPerLog2Q24 = 27'd101008905;
  localparam logic [28:0] KExpQ28      = 29'd367906976;
  localparam logic [29:0] Log2C225Q28  = 30'd577673932;
  localparam logic [31:0] A038         = 32'd1632087572;
  localparam logic [31:0] S01184       = 32'd508524127;
  localparam logic [31:0] C04          = 32'd1717986918;

  // |v| scaling to Q32 for VFrac = 16: constant multiply plus exact small divide
  localparam logic [15:0] Lin062Mul = 16'd40632;   // floor(0.62 * 2^16)
  localparam logic [12:0] Div10Mul  = 13'd6553;    // floor(2^16 / 10)
  localparam logic [19:0] Recip25   = 20'd671089;  // ceil(2^24 / 25), exact below 2^20
  localparam logic [19:0] Recip5    = 20'd838861;  // ceil(2^22 / 5), exact below 2^20

  // region codes
  localparam logic [2:0] RegZero = 3'd0;
  localparam logic [2:0] RegLin  = 3'd1;
  localparam logic [2:0] RegExp  = 3'd2;
  localparam logic [2:0] RegSqrt = 3'd3;
  localparam logic [2:0] RegInv  = 3'd4;
  localparam logic [2:0] RegMin  = 3'd5;

  // value in flight between pipeline stages
  typedef struct packed {
    logic        vld;
    logic [2:0]  region;
    logic [63:0] x;      // working operand
    logic [63:0] r;      // root / mantissa
    logic [63:0] aux;    // remainder / partial
    logic signed [39:0] l; // log2 accumulator, Q28
    logic [6:0]  p;      // leading-one position
  } stage_t;

endpackage

### src/kedl_front.sv
// ----------------------------------------------------------------------------
// kedl_front: region decode and operand preparation
// Classifies v and forms the log2 / square-root operand.
// ----------------------------------------------------------------------------
module kedl_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [kedl_pkg::VW-1:0] v_i,
  output kedl_pkg::stage_t       st_o
);
  logic signed [kedl_pkg::VW-1:0] v;
  logic [31:0] mag;
  logic [63:0] q;
  logic [19:0] n25, n5;
  logic [39:0] p25, p5;
  logic [33:0] q62, q10;
  kedl_pkg::stage_t st_d, st_q;

  assign v = $signed(v_i);

  always_comb begin
    st_d     = '0;
    st_d.vld = vld_i;
    mag      = 32'(v[kedl_pkg::VW-1] ? -34'(v) : 34'(v));
    q        = 64'(mag) << (32 - kedl_pkg::VFrac);
    // floor(0.62 q) = 40632|v| + floor(8|v| / 25), |v| < 1
    n25      = {1'b0, mag[15:0], 3'b000};
    p25      = 40'(n25) * 40'(kedl_pkg::Recip25);
    q62      = 34'(mag[15:0]) * 34'(kedl_pkg::Lin062Mul) + 34'(p25[39:24]);
    // floor(q / 10) = 6553|v| + floor(3|v| / 5), |v| <= 2.4
    n5       = {2'b00, mag[17:0]} + {1'b0, mag[17:0], 1'b0};
    p5       = 40'(n5) * 40'(kedl_pkg::Recip5);
    q10      = 34'(mag[17:0]) * 34'(kedl_pkg::Div10Mul) + 34'(p5[39:22]);
    if (v <= -$signed(25'(1 << kedl_pkg::VFrac))) begin
      st_d.region = kedl_pkg::RegZero;
    end else if (v <= 0) begin
      st_d.region = kedl_pkg::RegLin;
      st_d.x      = 64'h8000_0000 + 64'(q62);
    end else if (v <= $signed(25'(1 << kedl_pkg::VFrac))) begin
      st_d.region = kedl_pkg::RegExp;
      st_d.x      = q;
    end else if (27'(5) * 27'(v) <= 27'(12 << kedl_pkg::VFrac)) begin
      st_d.region = kedl_pkg::RegSqrt;
      st_d.x      = 64'(kedl_pkg::A038) - 64'(q10);
    end else begin
      st_d.region = kedl_pkg::RegInv;
      st_d.x      = 64'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;
endmodule

### src/kedl_sqrt.sv
// ----------------------------------------------------------------------------
// kedl_sqrt: square-root region pipeline
// Squares w, subtracts from 0.1184, then a 32-stage restoring root.
// ----------------------------------------------------------------------------
module kedl_sqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  kedl_pkg::stage_t st_i,
  output kedl_pkg::stage_t st_o
);
  localparam int unsigned NS = 34;
  kedl_pkg::stage_t pipe_q [NS];
  kedl_pkg::stage_t pipe_d [NS];

  always_comb begin
    logic [63:0] w2, d;
    logic [63:0] bitv;
    pipe_d[0] = st_i;
    w2 = (st_i.x[31:0] * st_i.x[31:0]) >> 32;
    pipe_d[0].aux = w2;
    d  = (pipe_q[0].aux > 64'(kedl_pkg::S01184)) ? 64'd0 :
         64'(kedl_pkg::S01184) - pipe_q[0].aux;
    pipe_d[1]     = pipe_q[0];
    pipe_d[1].aux = d << 32;
    pipe_d[1].r   = '0;
    for (int k = 2; k < NS; k++) begin
      pipe_d[k] = pipe_q[k-1];
      bitv = 64'd1 << (2 * (NS - 1 - k) );
      if (pipe_q[k-1].aux >= pipe_q[k-1].r + bitv) begin
        pipe_d[k].aux = pipe_q[k-1].aux - (pipe_q[k-1].r + bitv);
        pipe_d[k].r   = (pipe_q[k-1].r >> 1) + bitv;
      end else begin
        pipe_d[k].r   = pipe_q[k-1].r >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) pipe_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 0; k < NS; k++) pipe_q[k] <= pipe_d[k];
    end
  end

  // only the root region's result is taken; other regions pass x intact
  always_comb begin
    st_o = pipe_q[NS-1];
    if (pipe_q[NS-1].region == kedl_pkg::RegSqrt) begin
      if (pipe_q[NS-1].r >= 64'(kedl_pkg::C04)) begin
        st_o.region = kedl_pkg::RegMin;
        st_o.x      = '0;
      end else begin
        st_o.x = 64'(kedl_pkg::C04) - pipe_q[NS-1].r;
      end
    end
  end
endmodule

### src/kedl_log2.sv
// ----------------------------------------------------------------------------
// kedl_log2: log2 in Q28 by repeated squaring, one fraction bit per stage
// ----------------------------------------------------------------------------
module kedl_log2 (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  kedl_pkg::stage_t st_i,
  output kedl_pkg::stage_t st_o
);
  localparam int unsigned NS = kedl_pkg::LogFrac + 2;
  kedl_pkg::stage_t pipe_q [NS];
  kedl_pkg::stage_t pipe_d [NS];

  always_comb begin
    logic [6:0]  p;
    logic [63:0] sq;
    pipe_d[0] = st_i;
    p = '0;
    for (int b = 1; b < 64; b++) if (st_i.x[b]) p = 7'(b);
    pipe_d[0].p = p;
    pipe_d[1]   = pipe_q[0];
    pipe_d[1].r = (pipe_q[0].p >= 7'd31) ? pipe_q[0].x >> (pipe_q[0].p - 7'd31) :
                  pipe_q[0].x << (7'd31 - pipe_q[0].p);
    pipe_d[1].aux = '0;
    // exponential region needs no log: -1 - 0.95 log2(e) v
    pipe_d[1].l = -(40'sd1 <<< kedl_pkg::LogFrac) -
                  40'((64'(pipe_q[0].x[32:0]) * 64'(kedl_pkg::KExpQ28)) >> 32);
    for (int k = 2; k < NS; k++) begin
      pipe_d[k] = pipe_q[k-1];
      sq = (pipe_q[k-1].r[32:0] * pipe_q[k-1].r[32:0]) >> 31;
      if (sq[32]) begin
        pipe_d[k].r   = sq >> 1;
        pipe_d[k].aux = pipe_q[k-1].aux | (64'd1 << (NS - 1 - k));
      end else begin
        pipe_d[k].r   = sq;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) pipe_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 0; k < NS; k++) pipe_q[k] <= pipe_d[k];
    end
  end

  // combine integer part; region decides fractional scale and offsets
  always_comb begin
    logic signed [39:0] lg;
    logic signed [39:0] ip;
    kedl_pkg::stage_t s;
    s  = pipe_q[NS-1];
    ip = 40'(s.p);
    if (s.region == kedl_pkg::RegInv) ip = ip - 40'(kedl_pkg::VFrac);
    else ip = ip - 40'sd32;
    lg = (ip <<< kedl_pkg::LogFrac) + 40'(s.aux[27:0]);
    st_o = s;
    case (s.region)
      kedl_pkg::RegExp: st_o.l = s.l;
      kedl_pkg::RegInv: st_o.l = -40'(kedl_pkg::Log2C225Q28) - lg;
      default:          st_o.l = lg;
    endcase
  end
endmodule

### src/knife_edge_diffraction_loss.sv
// ----------------------------------------------------------------------------
// knife_edge_diffraction_loss: five-region knife-edge diffraction gain
// Maps Fresnel parameter v (Q8.16) to gain in dB (Q7.8), saturated.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries v, master channel m_axis_* carries gain.
//   One transaction in may enter every cycle while s_axis_tready is high;
//   each yields one transaction out. Stages in order: front decode,
//   square / root pipeline, log2 squaring pipeline, dB multiply, round,
//   output reg. Throughput is one item per cycle while no stall holds it,
//   set by the fully pipelined log2 and root chains (one bit per stage).
//   A stall on m_axis_tready freezes the whole pipeline; s_axis_tready drops
//   only while the output register holds an untaken result, so nothing is
//   lost or repeated.
//   Reset clears all valid bits; the block takes input the cycle after.
// ----------------------------------------------------------------------------
module knife_edge_diffraction_loss (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [23:0] fresnel_v
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [15:0] loss_db
);
  logic en;
  kedl_pkg::stage_t st_f, st_s, st_l;
  logic               m1_vld_q, m2_vld_q, out_vld_q;
  logic [2:0]         m1_reg_q;
  logic signed [67:0] prod_q;
  logic [15:0]        db_d, db_q, out_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  kedl_front u_front (.clk_i, .rst_ni, .en_i(en),
    .vld_i(s_axis_tvalid), .v_i(s_axis_tdata), .st_o(st_f));
  kedl_sqrt u_sqrt (.clk_i, .rst_ni, .en_i(en), .st_i(st_f), .st_o(st_s));
  kedl_log2 u_log2 (.clk_i, .rst_ni, .en_i(en), .st_i(st_s), .st_o(st_l));

  // round Q52 product half away from zero to Q8, saturate; RegZero forces 0
  always_comb begin
    logic        neg;
    logic [67:0] mag, r;
    neg = prod_q[67];
    mag = neg ? 68'(-prod_q) : 68'(prod_q);
    r   = (mag + (68'd1 << (51 - kedl_pkg::OutFrac))) >> (52 - kedl_pkg::OutFrac);
    if (m1_reg_q == kedl_pkg::RegZero) db_d = '0;
    else if (m1_reg_q == kedl_pkg::RegMin) db_d = 16'h8000;
    else if (neg) db_d = (r > 68'd32768) ? 16'h8000 : 16'(-r);
    else db_d = (r > 68'd32767) ? 16'h7fff : 16'(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q  <= 1'b0;
      m2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q  <= st_l.vld;
      m2_vld_q  <= m1_vld_q;
      out_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= 68'(st_l.l) * 68'(kedl_pkg::DbPerLog2Q24);
      m1_reg_q <= st_l.region;
      db_q     <= db_d;
      out_q    <= db_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && m2_vld_q |=> m_axis_tvalid)
    else $error("result lost at output stage");
endmodule

### dv/knife_edge_diffraction_loss_tb.sv
// ----------------------------------------------------------------------------
// knife_edge_diffraction_loss_tb: self-checking bench for the diffraction gain
// Drives v values over the slave stream, predicts each gain in dB with an
// integer model of the five regions, and checks every master transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module knife_edge_diffraction_loss_tb;

  localparam int unsigned NumRandom = 1500;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned LogFracBits = 28;
  localparam longint DbPerLog2 = 64'sd101008905;
  localparam longint ExpSlope = 64'sd367906976;
  localparam longint Log2Of0225 = 64'sd577673932;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [23:0] fresnel_v
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] loss_db

  logic [23:0] pending_v[$];   // v values waiting for the driver
  logic [15:0] gain_expected[$];
  int unsigned mismatches;
  int unsigned gains_checked;
  int unsigned idle_cycles;
  bit          timed_out;
  bit          hold_sender;
  bit          s_taken;        // input transaction at the last rising edge
  int unsigned send_gap;
  int unsigned recv_gap;

  knife_edge_diffraction_loss dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic queue_v(input logic [23:0] val);
    pending_v = {pending_v, val};
  endtask

  // log2 in Q28 of raw / 2^frac; mantissa squared bit by bit, truncating
  function automatic longint log2_fixed(logic [63:0] raw, int frac);
    int p;
    logic [63:0] mant;
    logic [127:0] sq;
    longint fr;
    p = 63;
    fr = 0;
    while (p > 0 && raw[p] == 1'b0) p--;
    if (p >= 31) mant = raw >> (p - 31);
    else mant = raw << (31 - p);
    for (int i = 0; i < LogFracBits; i++) begin
      sq = mant * mant;
      mant = sq[94:31];
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        fr = fr | (64'sd1 <<< (LogFracBits - 1 - i));
      end
    end
    return longint'(p - frac) * (64'sd1 <<< LogFracBits) + fr;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q28 log2 -> Q7.8 dB, rounded half away from zero, saturated
  function automatic logic [15:0] log2_to_gain(longint l);
    longint prod;
    logic [63:0] mag;
    logic [63:0] r;
    prod = l * DbPerLog2;
    mag = (prod < 0) ? 64'd0 - 64'(prod) : 64'(prod);
    r = (mag + (64'd1 << 43)) >> 44;
    if (prod < 0) return (r > 64'd32768) ? 16'h8000 : 16'(-r);
    return (r > 64'd32767) ? 16'h7fff : 16'(r);
  endfunction

  function automatic logic [15:0] predict_gain(logic [23:0] raw);
    longint v;
    longint one;
    logic [63:0] q, x, w, w2, d, r;
    logic [63:0] a038, s1184, c04;
    logic [127:0] wide;
    v = longint'($signed(raw));
    one = 64'sd1 <<< 16;
    a038 = (64'd38 << 32) / 100;
    s1184 = (64'd1184 << 32) / 10000;
    c04 = (64'd4 << 32) / 10;
    if (v <= -one) return 16'h0000;
    if (v <= 0) begin
      // -1 < v <= 0: linear region
      q = 64'(-v) << 16;
      x = (64'd1 << 31) + (64'd62 * q) / 100;
      return log2_to_gain(log2_fixed(x, 32));
    end
    if (v <= one) begin
      // 0 < v <= 1: exponential region
      q = 64'(v) << 16;
      wide = q * 64'(ExpSlope);
      return log2_to_gain(-(64'sd1 <<< LogFracBits) - longint'(wide[95:32]));
    end
    if (5 * v <= 12 * one) begin
      // 1 < v <= 2.4: square-root region
      q = 64'(v) << 16;
      w = a038 - q / 10;
      wide = w * w;
      w2 = wide[95:32];
      d = (w2 > s1184) ? 64'd0 : s1184 - w2;
      r = int_sqrt(d << 32);
      x = (r >= c04) ? 64'd0 : c04 - r;
      if (x == 0) return 16'h8000;
      return log2_to_gain(log2_fixed(x, 32));
    end
    // v > 2.4: inverse region
    return log2_to_gain(-Log2Of0225 - log2_fixed(64'(v), 16));
  endfunction

  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) s_taken <= s_axis_tvalid && s_axis_tready;

  // driver: holds tvalid until accepted, inserts random gaps
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_taken) begin
      // previous transaction (if any) was taken at the last rising edge
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_v.size() != 0 && !hold_sender) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_v.pop_front();
        send_gap      <= random_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else if (recv_gap != 0) begin
      recv_gap      <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap      <= ($urandom_range(0, 2) == 0) ? random_gap() : 0;
    end
  end

  // monitor: predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        gain_expected = {gain_expected, predict_gain(s_axis_tdata)};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        gains_checked <= gains_checked + 1;
        if (gain_expected.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected gain transaction: loss_db=%0d", $signed(m_axis_tdata));
        end else begin
          if (gain_expected[0] !== m_axis_tdata) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("loss_db mismatch: expected %0d actual %0d",
                       $signed(gain_expected[0]), $signed(m_axis_tdata));
          end
          void'(gain_expected.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [23:0] v;
    int unsigned pick;
    rst_ni        = 1'b0;
    mismatches    = 0;
    gains_checked = 0;
    idle_cycles   = 0;
    timed_out     = 1'b0;
    hold_sender   = 1'b1;
    // directed: field extremes and each region boundary
    queue_v(24'h800000);  // most negative
    queue_v(24'h7fffff);  // most positive
    queue_v(24'hff0000);  // v = -1
    queue_v(24'hff0001);  // just above -1
    queue_v(24'hffffff);
    queue_v(24'h000000);  // v = 0
    queue_v(24'h000001);
    queue_v(24'h010000);  // v = 1
    queue_v(24'h010001);
    queue_v(24'h026666);  // near 2.4
    queue_v(24'h026667);
    queue_v(24'h020000);
    queue_v(24'h555555);
    queue_v(24'haaaaaa);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    hold_sender = 1'b0;
    // random: mostly the interesting span around the bounded regions
    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) v = 24'($signed($urandom_range(0, 262144)) - 98304);  // -1.5..2.5
      else if (pick < 8) v = 24'($urandom_range(0, 24'h7fffff));
      else v = 24'($urandom);
      queue_v(v);
    end
    // wait for the directed and half the random items, then drain fully
    wait (pending_v.size() < NumRandom / 2);
    @(negedge clk_i);
    hold_sender = 1'b1;
    wait (gain_expected.size() == 0 && !s_axis_tvalid);
    @(negedge clk_i);
    hold_sender = 1'b0;
    wait (pending_v.size() == 0 && !s_axis_tvalid);
    wait (gain_expected.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("checked %0d gain results over all five regions, edges and saturation",
             gains_checked);
    $display("with random stalls on both streams and one full drain mid-run");
    if (mismatches == 0 && gain_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/kedl_pkg.sv
src/kedl_front.sv
src/kedl_sqrt.sv
src/kedl_log2.sv
src/knife_edge_diffraction_loss.sv
dv/knife_edge_diffraction_loss_tb.sv
